FILE: sv/pbs_pkg.sv
// Shared types, constants and arithmetic helpers for the pixel background subtractor.
package pbs_pkg;

    localparam int NUM_PIXELS_DEF = 131072;
    localparam int IDX_W          = 17;
    localparam int CH_W           = 8;
    localparam int BG_W           = 3 * CH_W;
    localparam int CNT_W          = 8;
    localparam int ALPHA_W        = 9;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECTIVE_UPDATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_ENABLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_TAU        = 3'd6;

    localparam logic [CH_W-1:0]    RST_DIFF_THRESHOLD = 8'd30;
    localparam logic               RST_COLOR_MODE     = 1'b1;
    localparam logic [ALPHA_W-1:0] RST_BLEND_ALPHA    = 9'd13;
    localparam logic [CH_W-1:0]    RST_GHOST_TAU      = 8'd100;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 8'd255;

    localparam logic [21:0] GRAY_R_COEF = 22'd4899;
    localparam logic [21:0] GRAY_G_COEF = 22'd9617;
    localparam logic [21:0] GRAY_B_COEF = 22'd1868;
    localparam logic [21:0] GRAY_ROUND  = 22'd8192;
    localparam logic [17:0] BLEND_ROUND = 18'd128;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             init_frame;
    } t_pixel_req;

    typedef struct packed {
        logic foreground;
        logic absorbed;
    } t_result_req;

    typedef struct packed {
        logic [CH_W-1:0]    diff_threshold;
        logic               color_mode;
        logic [ALPHA_W-1:0] blend_alpha;
        logic               update_enable;
        logic               selective_update;
        logic               ghost_enable;
        logic [CH_W-1:0]    ghost_tau;
    } t_cfg;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_stage_ld;

    typedef struct packed {
        logic             bg_we;
        logic             cnt_we;
        logic [BG_W-1:0]  bg;
        logic [CNT_W-1:0] cnt;
    } t_store_wr;

    function automatic logic [CH_W-1:0] to_gray(input logic [CH_W-1:0] r,
                                                input logic [CH_W-1:0] g,
                                                input logic [CH_W-1:0] b);
        logic [21:0] sum;
        sum = GRAY_R_COEF * 22'(r) + GRAY_G_COEF * 22'(g) + GRAY_B_COEF * 22'(b)
            + GRAY_ROUND;
        return sum[21:14];
    endfunction

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] x,
                                                 input logic [CH_W-1:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0]    pix,
                                              input logic [CH_W-1:0]    bg,
                                              input logic [ALPHA_W-1:0] a);
        logic [ALPHA_W-1:0] inv;
        logic [17:0]        sum;
        inv = ALPHA_ONE - a;
        sum = 18'(a) * 18'(pix) + 18'(inv) * 18'(bg) + BLEND_ROUND;
        return sum[15:8];
    endfunction

endpackage

FILE: sv/pixel_background_subtractor_core.sv
// Top level of the pixel background subtractor: handshake, interlock, config and result register.
//
// Accepts one pixel request per clock unless stalled by the output or an index hazard, and
// passes it through the read stage, two compute stages, then the output register. The per-pixel
// background and still counter sit in a single-port-read, single-port-write store; a request
// whose pixel index matches one of the up to three requests still between read and write-back
// is held until that write-back lands; a stalled output also holds back the write-back.
// Store contents are undefined after reset: send an init request for every pixel
// before a normal request touches it. Requests with pixel_index at or above NUM_PIXELS
// change no state and return foreground 0, absorbed 0. Write configuration only while
// no request is in flight.
module pixel_background_subtractor_core #(
    parameter int NUM_PIXELS = pbs_pkg::NUM_PIXELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pbs_pkg::t_pixel_req               i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pbs_pkg::t_result_req              o_out_req,
    input  logic                              i_cfg_we,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    pbs_pkg::t_cfg        r_cfg;
    pbs_pkg::t_stage_ld   w_ld;
    pbs_pkg::t_store_wr   w_calc_wr;
    pbs_pkg::t_store_wr   w_wr;
    pbs_pkg::t_result_req w_result;
    pbs_pkg::t_result_req r_out_req;

    logic r_v1, r_v2, r_v3, r_out_valid;
    logic [pbs_pkg::IDX_W-1:0] r_idx1, r_idx2, r_idx3;
    logic r_inr1, r_inr2, r_inr3;

    logic w_out_free, w_free3, w_free2, w_free1;
    logic w_hazard, w_accept, w_mv3, w_in_range;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [pbs_pkg::BG_W-1:0]  w_bg_rdata;
    logic [pbs_pkg::CNT_W-1:0] w_cnt_rdata;

    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_free3    = !r_v3 || w_out_free;
        w_free2    = !r_v2 || w_free3;
        w_free1    = !r_v1 || w_free2;
        w_hazard   = (r_v1 && (r_idx1 == i_in_req.pixel_index))
                  || (r_v2 && (r_idx2 == i_in_req.pixel_index))
                  || (r_v3 && (r_idx3 == i_in_req.pixel_index));
        w_accept   = i_in_valid && w_free1 && !w_hazard;
        w_mv3      = r_v3 && w_out_free;
        w_ld.ld1   = w_accept;
        w_ld.ld2   = r_v1 && w_free2;
        w_ld.ld3   = r_v2 && w_free3;
        w_in_range = {15'd0, i_in_req.pixel_index} < 32'(NUM_PIXELS);
        w_rd_addr  = AW'(i_in_req.pixel_index);
        w_wr_addr  = AW'(r_idx3);
        w_wr.bg_we  = w_mv3 && r_inr3 && w_calc_wr.bg_we;
        w_wr.cnt_we = w_mv3 && r_inr3 && w_calc_wr.cnt_we;
        w_wr.bg     = w_calc_wr.bg;
        w_wr.cnt    = w_calc_wr.cnt;
    end

    assign o_in_stall  = !w_free1 || w_hazard;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_free1) begin
                r_v1 <= w_accept;
            end
            if (w_free2) begin
                r_v2 <= r_v1;
            end
            if (w_free3) begin
                r_v3 <= r_v2;
            end
            if (w_out_free) begin
                r_out_valid <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld.ld1) begin
            r_idx1 <= i_in_req.pixel_index;
            r_inr1 <= w_in_range;
        end
        if (w_ld.ld2) begin
            r_idx2 <= r_idx1;
            r_inr2 <= r_inr1;
        end
        if (w_ld.ld3) begin
            r_idx3 <= r_idx2;
            r_inr3 <= r_inr2;
        end
        if (w_mv3) begin
            r_out_req <= r_inr3 ? w_result : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_threshold   <= pbs_pkg::RST_DIFF_THRESHOLD;
            r_cfg.color_mode       <= pbs_pkg::RST_COLOR_MODE;
            r_cfg.blend_alpha      <= pbs_pkg::RST_BLEND_ALPHA;
            r_cfg.update_enable    <= 1'b0;
            r_cfg.selective_update <= 1'b0;
            r_cfg.ghost_enable     <= 1'b0;
            r_cfg.ghost_tau        <= pbs_pkg::RST_GHOST_TAU;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pbs_pkg::CFG_DIFF_THRESHOLD:   r_cfg.diff_threshold   <= i_cfg_wdata[7:0];
                pbs_pkg::CFG_COLOR_MODE:       r_cfg.color_mode       <= i_cfg_wdata[0];
                pbs_pkg::CFG_BLEND_ALPHA:      r_cfg.blend_alpha      <= i_cfg_wdata;
                pbs_pkg::CFG_UPDATE_ENABLE:    r_cfg.update_enable    <= i_cfg_wdata[0];
                pbs_pkg::CFG_SELECTIVE_UPDATE: r_cfg.selective_update <= i_cfg_wdata[0];
                pbs_pkg::CFG_GHOST_ENABLE:     r_cfg.ghost_enable     <= i_cfg_wdata[0];
                pbs_pkg::CFG_GHOST_TAU:        r_cfg.ghost_tau        <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    pbs_store #(
        .DEPTH (NUM_PIXELS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_en     (w_accept),
        .i_rd_addr   (w_rd_addr),
        .o_bg_rdata  (w_bg_rdata),
        .o_cnt_rdata (w_cnt_rdata),
        .i_wr        (w_wr),
        .i_wr_addr   (w_wr_addr)
    );

    pbs_calc u_calc (
        .i_clk       (i_clk),
        .i_ld        (w_ld),
        .i_cfg       (r_cfg),
        .i_in_req    (i_in_req),
        .i_bg_rdata  (w_bg_rdata),
        .i_cnt_rdata (w_cnt_rdata),
        .o_wr        (w_calc_wr),
        .o_result    (w_result)
    );

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_wr.bg_we) |-> (w_rd_addr != w_wr_addr))
        else $error("read and write-back hit the same entry");

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_free3) |=> (r_v2 && $stable(r_idx2)))
        else $error("stage 2 request lost while blocked");

    a_out_from_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v3))
        else $error("result appeared without a request in stage 3");

    a_absorb_needs_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_req.absorbed || o_out_req.foreground))
        else $error("absorbed result without foreground");

endmodule

FILE: sv/pbs_store.sv
// Background and still-counter memories, one registered read port and one write port.
module pbs_store #(
    parameter int DEPTH = pbs_pkg::NUM_PIXELS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [AW-1:0]                  i_rd_addr,
    output logic [pbs_pkg::BG_W-1:0]       o_bg_rdata,
    output logic [pbs_pkg::CNT_W-1:0]      o_cnt_rdata,
    input  pbs_pkg::t_store_wr             i_wr,
    input  logic [AW-1:0]                  i_wr_addr
);

    logic [pbs_pkg::BG_W-1:0]  r_bg_mem  [DEPTH];
    logic [pbs_pkg::CNT_W-1:0] r_cnt_mem [DEPTH];
    logic [pbs_pkg::BG_W-1:0]  r_bg_rdata;
    logic [pbs_pkg::CNT_W-1:0] r_cnt_rdata;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_bg_rdata  <= r_bg_mem[i_rd_addr];
            r_cnt_rdata <= r_cnt_mem[i_rd_addr];
        end
        if (i_wr.bg_we) begin
            r_bg_mem[i_wr_addr] <= i_wr.bg;
        end
        if (i_wr.cnt_we) begin
            r_cnt_mem[i_wr_addr] <= i_wr.cnt;
        end
    end

    assign o_bg_rdata  = r_bg_rdata;
    assign o_cnt_rdata = r_cnt_rdata;

endmodule

FILE: sv/pbs_calc.sv
// Classification, blend and ghost datapath across three pipeline stages.
module pbs_calc (
    input  logic                      i_clk,
    input  pbs_pkg::t_stage_ld        i_ld,
    input  pbs_pkg::t_cfg             i_cfg,
    input  pbs_pkg::t_pixel_req       i_in_req,
    input  logic [pbs_pkg::BG_W-1:0]  i_bg_rdata,
    input  logic [pbs_pkg::CNT_W-1:0] i_cnt_rdata,
    output pbs_pkg::t_store_wr        o_wr,
    output pbs_pkg::t_result_req      o_result
);

    pbs_pkg::t_pixel_req r_s1_req;

    logic [pbs_pkg::BG_W-1:0]  r_s2_pix,  n_s2_pix;
    logic [pbs_pkg::BG_W-1:0]  r_s2_bg,   n_s2_bg;
    logic [pbs_pkg::CNT_W-1:0] r_s2_cnt;
    logic                      r_s2_init;

    logic [pbs_pkg::BG_W-1:0]  r_s3_pix;
    logic [pbs_pkg::BG_W-1:0]  r_s3_bg,   n_s3_bg;
    logic [pbs_pkg::CNT_W-1:0] r_s3_cnt,  n_s3_cnt;
    logic                      r_s3_fg,   n_s3_fg;
    logic                      r_s3_init;

    logic [pbs_pkg::CH_W-1:0]    w_pix_gray;
    logic [pbs_pkg::CH_W-1:0]    w_bg_gray;
    logic [pbs_pkg::BG_W-1:0]    w_blended;
    logic [pbs_pkg::ALPHA_W-1:0] w_alpha;
    logic                        w_fg_r, w_fg_g, w_fg_b;
    logic                        w_absorb;

    // stage 1: pixel and stored background, passed through in colour mode or converted to gray
    always_comb begin
        w_pix_gray = pbs_pkg::to_gray(r_s1_req.red, r_s1_req.green, r_s1_req.blue);
        w_bg_gray  = pbs_pkg::to_gray(i_bg_rdata[23:16], i_bg_rdata[15:8],
                                      i_bg_rdata[7:0]);
        if (i_cfg.color_mode) begin
            n_s2_pix = {r_s1_req.red, r_s1_req.green, r_s1_req.blue};
            n_s2_bg  = i_bg_rdata;
        end else begin
            n_s2_pix = {w_pix_gray, w_pix_gray, w_pix_gray};
            n_s2_bg  = {w_bg_gray, w_bg_gray, w_bg_gray};
        end
    end

    // stage 2: threshold, blend and counter
    always_comb begin
        w_fg_r  = pbs_pkg::abs_diff(r_s2_pix[23:16], r_s2_bg[23:16]) > i_cfg.diff_threshold;
        w_fg_g  = pbs_pkg::abs_diff(r_s2_pix[15:8], r_s2_bg[15:8]) > i_cfg.diff_threshold;
        w_fg_b  = pbs_pkg::abs_diff(r_s2_pix[7:0], r_s2_bg[7:0]) > i_cfg.diff_threshold;
        n_s3_fg = i_cfg.color_mode ? (w_fg_r || w_fg_g || w_fg_b) : w_fg_r;
        w_alpha = (i_cfg.blend_alpha > pbs_pkg::ALPHA_ONE) ? pbs_pkg::ALPHA_ONE
                                                           : i_cfg.blend_alpha;
        w_blended = {pbs_pkg::blend(r_s2_pix[23:16], r_s2_bg[23:16], w_alpha),
                     pbs_pkg::blend(r_s2_pix[15:8], r_s2_bg[15:8], w_alpha),
                     pbs_pkg::blend(r_s2_pix[7:0], r_s2_bg[7:0], w_alpha)};
        if (i_cfg.update_enable && (!i_cfg.selective_update || !n_s3_fg)) begin
            n_s3_bg = w_blended;
        end else begin
            n_s3_bg = r_s2_bg;
        end
        if (!n_s3_fg) begin
            n_s3_cnt = '0;
        end else if (r_s2_cnt == pbs_pkg::CNT_MAX) begin
            n_s3_cnt = pbs_pkg::CNT_MAX;
        end else begin
            n_s3_cnt = r_s2_cnt + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_s1_req <= i_in_req;
        end
        if (i_ld.ld2) begin
            r_s2_pix  <= n_s2_pix;
            r_s2_bg   <= n_s2_bg;
            r_s2_cnt  <= i_cnt_rdata;
            r_s2_init <= r_s1_req.init_frame;
        end
        if (i_ld.ld3) begin
            r_s3_pix  <= r_s2_pix;
            r_s3_bg   <= n_s3_bg;
            r_s3_cnt  <= n_s3_cnt;
            r_s3_fg   <= n_s3_fg;
            r_s3_init <= r_s2_init;
        end
    end

    // stage 3: ghost absorption and write-back
    always_comb begin
        w_absorb    = !r_s3_init && i_cfg.ghost_enable && (r_s3_cnt > i_cfg.ghost_tau);
        o_wr.bg_we  = 1'b1;
        o_wr.cnt_we = r_s3_init || i_cfg.ghost_enable;
        o_wr.bg     = (r_s3_init || w_absorb) ? r_s3_pix : r_s3_bg;
        o_wr.cnt    = r_s3_init ? '0 : r_s3_cnt;
        o_result.foreground = !r_s3_init && r_s3_fg;
        o_result.absorbed   = w_absorb;
    end

endmodule
